### hw/rtl/bounded_fifo_drop_oldest_lookup_defines.svh
// Assertion macros used by the RTL.
// ASSERT_IMP: when pre holds, post holds at the same edge.
// ASSERT_NXT: when pre holds, post holds at the next edge.
`ifndef BOUNDED_FIFO_DROP_OLDEST_LOOKUP_DEFINES_SVH
`define BOUNDED_FIFO_DROP_OLDEST_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
`define ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### hw/rtl/bfdol_pkg.sv
package bfdol_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;

	localparam int ACT_W  = 2;
	localparam int ID_W   = 16;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 6;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [ID_W-1:0]   conn_id;
		logic [IP_W-1:0]   client_ip;
		logic [PORT_W-1:0] client_port;
	} req_beat_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic              dropped;
		logic [ID_W-1:0]   out_id;
		logic [IP_W-1:0]   out_ip;
		logic [PORT_W-1:0] out_port;
		logic [OCC_W-1:0]  occupancy;
	} rsp_beat_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
	} entry_t;

endpackage

### hw/rtl/bounded_fifo_drop_oldest_lookup.sv
// Bounded queue of pending connections (id, IPv4 address, port) held in one
// QUEUE_DEPTH-entry RAM, with a head pointer and an entry count. Each request
// beat carries an action: push appends at the tail and, on a full queue,
// evicts the oldest entry first and reports dropped; pop returns and removes
// the head entry or reports empty; lookup scans from the head and returns
// the first entry whose id matches, or reports not found; action 3 only
// reports the occupancy. Every request gives exactly one response beat.
// Each request is taken into a command register and dispatched; push and
// no-op then go to the response state, pop first reads the head entry, and
// lookup first scans the live entries. A lookup scan goes through the
// single RAM read port and the one id comparator: one entry is read per
// cycle, and each read is compared the cycle after it issues. req_ready is
// high only while no request is in progress; a finished response may still
// sit in the output register while the next request is taken. RAM contents
// are not cleared at reset; only live entries are ever read.
`include "bounded_fifo_drop_oldest_lookup_defines.svh"

module bounded_fifo_drop_oldest_lookup
	import bfdol_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_beat_t rsp
);

	// index width (at least 1) and count width (holds QUEUE_DEPTH itself)
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_POP_RD,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t          state_q;
	req_beat_t       cmd_q;
	rsp_beat_t       res_q;
	rsp_beat_t       rsp_q;
	logic            rsp_valid_q;
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   scan_idx_q;
	logic            cmp_vld_q;

	// entry RAM: one write port, one registered read port
	entry_t          mem [QUEUE_DEPTH];
	entry_t          rd_data_q;

	logic            full;
	logic            empty;
	logic [IW-1:0]   head_nxt;
	logic [IW-1:0]   tail_slot;
	logic [IW-1:0]   scan_slot;
	logic [CW-1:0]   count_push;
	logic            scan_issue;
	logic            match;
	logic            mem_we;
	logic            mem_re;
	logic [IW-1:0]   wr_addr;
	logic [IW-1:0]   rd_addr;
	entry_t          wr_data;
	rsp_beat_t       disp_res;
	logic            rsp_load;

	// head + offset, both below QUEUE_DEPTH, folded back into range
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
			input logic [IW-1:0] b);
		logic [IW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IW+1)'(QUEUE_DEPTH))
			s = s - (IW+1)'(QUEUE_DEPTH);
		return s[IW-1:0];
	endfunction

	function automatic logic [OCC_W-1:0] to_occ(input logic [CW-1:0] c);
		logic [CW+OCC_W-1:0] t;
		t = {{OCC_W{1'b0}}, c};
		return t[OCC_W-1:0];
	endfunction

	always_comb begin
		full       = (count_q == CW'(QUEUE_DEPTH));
		empty      = (count_q == '0);
		head_nxt   = wrap_add(head_q, IW'(1));
		// count is below depth whenever the tail slot is used
		tail_slot  = wrap_add(head_q, count_q[IW-1:0]);
		scan_slot  = wrap_add(head_q, scan_idx_q[IW-1:0]);
		count_push = full ? count_q : count_q + 1'b1;
		scan_issue = (scan_idx_q < count_q);
		// the single comparator: id of the entry read last cycle vs. key
		match      = cmp_vld_q && (rd_data_q.id == cmd_q.conn_id);

		mem_we  = (state_q == ST_DISPATCH) && (cmd_q.action == ACT_PUSH);
		wr_addr = full ? head_q : tail_slot;
		wr_data = '{id: cmd_q.conn_id, ip: cmd_q.client_ip, port: cmd_q.client_port};

		mem_re  = ((state_q == ST_DISPATCH) && (cmd_q.action == ACT_POP) && !empty)
			|| ((state_q == ST_SCAN) && scan_issue);
		rd_addr = (state_q == ST_SCAN) ? scan_slot : head_q;

		// output register takes a new beat when empty or being drained
		rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);

		// response fields known at dispatch
		disp_res           = '0;
		disp_res.occupancy = to_occ(count_q);
		case (cmd_q.action)
			ACT_PUSH: begin
				disp_res.dropped   = full;
				disp_res.occupancy = to_occ(count_push);
			end
			ACT_POP: begin
				if (empty)
					disp_res.status = STAT_EMPTY;
			end
			ACT_LOOKUP: begin
				if (empty)
					disp_res.status = STAT_EMPTY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		if (mem_re)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			head_q      <= '0;
			count_q     <= '0;
			scan_idx_q  <= '0;
			cmp_vld_q   <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q   <= req;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					res_q <= disp_res;
					case (cmd_q.action)
						ACT_PUSH: begin
							// full: the write lands on the old head slot
							if (full)
								head_q <= head_nxt;
							count_q <= count_push;
							state_q <= ST_RESP;
						end
						ACT_POP: begin
							if (empty) begin
								state_q <= ST_RESP;
							end else begin
								head_q  <= head_nxt;
								count_q <= count_q - 1'b1;
								state_q <= ST_POP_RD;
							end
						end
						ACT_LOOKUP: begin
							if (empty) begin
								state_q <= ST_RESP;
							end else begin
								scan_idx_q <= '0;
								cmp_vld_q  <= 1'b0;
								state_q    <= ST_SCAN;
							end
						end
						default: begin
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_POP_RD: begin
					res_q.found     <= 1'b1;
					res_q.out_id    <= rd_data_q.id;
					res_q.out_ip    <= rd_data_q.ip;
					res_q.out_port  <= rd_data_q.port;
					res_q.occupancy <= to_occ(count_q);
					state_q         <= ST_RESP;
				end
				ST_SCAN: begin
					// read one entry and compare the previous one each beat
					if (scan_issue)
						scan_idx_q <= scan_idx_q + 1'b1;
					cmp_vld_q <= scan_issue && !match;
					if (match) begin
						res_q.found    <= 1'b1;
						res_q.out_id   <= rd_data_q.id;
						res_q.out_ip   <= rd_data_q.ip;
						res_q.out_port <= rd_data_q.port;
						state_q        <= ST_RESP;
					end else if (cmp_vld_q && !scan_issue) begin
						res_q.status <= STAT_NOT_FOUND;
						state_q      <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_load) begin
						rsp_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH), "count above depth")
	`ASSERT_IMP(a_head_bound, clk, arst_n, 1'b1, head_q < IW'(QUEUE_DEPTH) || QUEUE_DEPTH == (1 << IW), "head out of range")
	`ASSERT_NXT(a_accept_dispatch, clk, arst_n, req_valid && req_ready, state_q == ST_DISPATCH, "accepted beat not dispatched")
	`ASSERT_IMP(a_found_ok, clk, arst_n, rsp_valid && rsp.found, rsp.status == STAT_OK && !rsp.dropped, "found with bad status")
	`ASSERT_IMP(a_drop_full, clk, arst_n, rsp_valid && rsp.dropped, rsp.occupancy == to_occ(CW'(QUEUE_DEPTH)), "drop without full queue")
	`ASSERT_IMP(a_scan_range, clk, arst_n, state_q == ST_SCAN, scan_idx_q <= count_q && !empty, "scan index past tail")

endmodule
